// File: design/lsfh_pkg.sv
// ----------------------------------------------------------------------------
// lsfh_pkg: shared types and constants of the sparkle-fade renderer
// Field widths, register indexes, reset values and the reciprocal
// constants used by the shared multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfh_pkg;

  localparam int NUM_LEDS_DEF = 60;

  localparam int IDX_W      = 6;
  localparam int HUE_W      = 9;
  localparam int PCT_W      = 7;
  localparam int COLOR_W    = 8;
  localparam int EXTRA_W    = 5;
  localparam int SAT_W      = 8;
  localparam int DIM_AMT_W  = 6;
  localparam int SECTOR_W   = 3;
  localparam int FRAC_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int DIM_BASE    = 25;
  localparam int FADE_STEP   = 7;
  localparam int PCT_MAX     = 100;
  localparam int HUE_FULL    = 360;
  localparam int SECTOR_SPAN = 60;
  localparam int RGB_FULL    = 255;

  // floor(p / d) = (p * ceil(2^23 / d)) >> 23, exact for p < 2^16
  localparam int PROD_W    = 16;
  localparam int RECIP_W   = 18;
  localparam int DIV_SHIFT = 23;
  localparam int RECIP_100 = 83887;
  localparam int RECIP_60  = 139811;

  localparam logic [CFG_IDX_W-1:0] REG_HUE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_ON   = 2'd3;

  localparam logic [HUE_W-1:0] HUE_RST        = 9'd0;
  localparam logic [PCT_W-1:0] SAT_LIMIT_RST  = 7'd100;
  localparam logic [PCT_W-1:0] BRIGHTNESS_RST = 7'd100;
  localparam logic             STRIP_ON_RST   = 1'b1;

  typedef enum logic {
    DIV_100,
    DIV_60
  } div_sel_e;

  typedef struct packed {
    logic [COLOR_W-1:0] op_a;
    logic [COLOR_W-1:0] op_b;
    div_sel_e           div_sel;
  } md_req_t;

endpackage

`default_nettype wire

// File: design/lsfh_ram.sv
// ----------------------------------------------------------------------------
// lsfh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/lsfh_muldiv.sv
// ----------------------------------------------------------------------------
// lsfh_muldiv: shared scaled-product unit
// Computes floor(a * b / 100) or floor(a * b / 60) in two register stages:
// product first, then multiplication by the reciprocal and a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfh_muldiv
  import lsfh_pkg::*;
(
  input  logic               clk_i,
  input  md_req_t            req_i,
  output logic [COLOR_W-1:0] quot_o
);

  logic [PROD_W-1:0]         prod_q;
  div_sel_e                  sel_q;
  logic [COLOR_W-1:0]        quot_q;
  logic [RECIP_W-1:0]        recip;
  logic [PROD_W+RECIP_W-1:0] scaled;

  always_comb begin
    case (sel_q)
      DIV_60:  recip = RECIP_W'(RECIP_60);
      default: recip = RECIP_W'(RECIP_100);
    endcase
    scaled = (PROD_W+RECIP_W)'(prod_q) * (PROD_W+RECIP_W)'(recip);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_i.op_a) * PROD_W'(req_i.op_b);
    sel_q  <= req_i.div_sel;
    quot_q <= scaled[DIV_SHIFT +: COLOR_W];
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: design/led_sparkle_fade_hsv_renderer.sv
// ----------------------------------------------------------------------------
// led_sparkle_fade_hsv_renderer: per-LED saturation fade with HSV output
// Dim requests lower one LED's level; frame requests fade every level and
// stream one RGB pixel per LED through a shared multiply/divide unit.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_we_i               cfg_index_i, cfg_data_i
//   in        in         in_valid_i/in_ready_o  req_type_i, led_index_i,
//                                               dim_extra_i
//   out       out        out_valid_o/out_ready_i pixel_index_o, red_o,
//                                               green_o, blue_o, last_o
//
// A dim request reads the RAM, then writes the level back; one beyond the
// strip is accepted without a RAM access.
// A frame request first scales the brightness through the shared two-stage
// unit; each LED then uses it twice (min and adjust terms).
// Reset clears the levels through one valid bit per LED; no clearing pass.
// The output register holds one pixel; the block waits in its emit step
// while the previous pixel is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module led_sparkle_fade_hsv_renderer
  import lsfh_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [IDX_W-1:0]      led_index_i,
  input  logic [EXTRA_W-1:0]    dim_extra_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [IDX_W-1:0]      pixel_index_o,
  output logic [COLOR_W-1:0]    red_o,
  output logic [COLOR_W-1:0]    green_o,
  output logic [COLOR_W-1:0]    blue_o,
  output logic                  last_o
);

  localparam int LED_AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IDX_W:0]   LED_COUNT = (IDX_W+1)'(NUM_LEDS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_LEDS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIM_WR = 4'd1;
  localparam logic [3:0] S_TOP_W1 = 4'd2;
  localparam logic [3:0] S_TOP_W2 = 4'd3;
  localparam logic [3:0] S_FADE   = 4'd4;
  localparam logic [3:0] S_BOT_W1 = 4'd5;
  localparam logic [3:0] S_BOT_W2 = 4'd6;
  localparam logic [3:0] S_ADJ_W1 = 4'd7;
  localparam logic [3:0] S_ADJ_W2 = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [IDX_W-1:0]     cnt_q, cnt_next;
  logic [DIM_AMT_W-1:0] dim_amt_q;
  logic [SECTOR_W-1:0]  sector_q, sector;
  logic [FRAC_W-1:0]    frac_q, frac;
  logic [COLOR_W-1:0]   top_q, bot_q, adj_q;
  logic [NUM_LEDS-1:0]  vld_q;
  logic                 rd_vld_q;

  logic [HUE_W-1:0]     hue_q;
  logic [PCT_W-1:0]     sat_limit_q, brightness_q;
  logic                 strip_on_q;

  logic                 out_valid_q, out_last_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic [COLOR_W-1:0]   out_red_q, out_green_q, out_blue_q;

  logic                 in_fire, dim_ok, out_free, out_load;
  logic                 rd_en, wr_en;
  logic [LED_AW-1:0]    rd_addr, wr_addr;
  logic [SAT_W-1:0]     wr_data, ram_rdata, sat_cur;
  logic [HUE_W-1:0]     hue_mod, hue_base;
  logic [PCT_W-1:0]     val_pct, fade_lvl, s_conv, s_comp;
  logic [SAT_W:0]       fade_sum, dim_diff;
  logic [SAT_W-1:0]     dim_lvl;
  logic [COLOR_W-1:0]   md_quot, red, green, blue;
  md_req_t              md_req;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign dim_ok     = ({1'b0, led_index_i} < LED_COUNT);
  assign out_free   = !out_valid_q || out_ready_i;
  assign cnt_next   = cnt_q + IDX_W'(1);

  // hue sector and offset
  always_comb begin
    hue_mod = (hue_q >= HUE_W'(HUE_FULL)) ? hue_q - HUE_W'(HUE_FULL) : hue_q;
    if (hue_mod >= HUE_W'(5 * SECTOR_SPAN)) begin
      sector = 3'd5;
    end else if (hue_mod >= HUE_W'(4 * SECTOR_SPAN)) begin
      sector = 3'd4;
    end else if (hue_mod >= HUE_W'(3 * SECTOR_SPAN)) begin
      sector = 3'd3;
    end else if (hue_mod >= HUE_W'(2 * SECTOR_SPAN)) begin
      sector = 3'd2;
    end else if (hue_mod >= HUE_W'(SECTOR_SPAN)) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    hue_base = HUE_W'(sector) * HUE_W'(SECTOR_SPAN);
    frac     = FRAC_W'(hue_mod - hue_base);
  end

  always_comb begin
    if (!strip_on_q) begin
      val_pct = '0;
    end else if (brightness_q > PCT_W'(PCT_MAX)) begin
      val_pct = PCT_W'(PCT_MAX);
    end else begin
      val_pct = brightness_q;
    end
  end

  // level arithmetic on the stored entry
  always_comb begin
    sat_cur  = rd_vld_q ? ram_rdata : '0;
    fade_sum = {sat_cur[SAT_W-1], sat_cur} + (SAT_W+1)'(FADE_STEP);
    if (fade_sum[SAT_W]) begin
      fade_lvl = '0;
    end else if (fade_sum[SAT_W-1:0] > {1'b0, sat_limit_q}) begin
      fade_lvl = sat_limit_q;
    end else begin
      fade_lvl = fade_sum[PCT_W-1:0];
    end
    s_conv   = (fade_lvl > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : fade_lvl;
    s_comp   = PCT_W'(PCT_MAX) - s_conv;
    dim_diff = {sat_cur[SAT_W-1], sat_cur} - (SAT_W+1)'(dim_amt_q);
    dim_lvl  = (dim_diff[SAT_W] && !dim_diff[SAT_W-1]) ? {1'b1, {(SAT_W-1){1'b0}}}
                                                         : dim_diff[SAT_W-1:0];
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    rd_en    = 1'b0;
    rd_addr  = cnt_q[LED_AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = cnt_q[LED_AW-1:0];
    wr_data  = {1'b0, fade_lvl};
    out_load = 1'b0;
    md_req   = '{op_a: '0, op_b: '0, div_sel: DIV_100};
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (req_type_i) begin
            md_req  = '{op_a: {1'b0, val_pct}, op_b: COLOR_W'(RGB_FULL), div_sel: DIV_100};
            state_d = S_TOP_W1;
          end else if (dim_ok) begin
            rd_en   = 1'b1;
            rd_addr = led_index_i[LED_AW-1:0];
            state_d = S_DIM_WR;
          end
        end
      end
      S_DIM_WR: begin
        wr_en   = 1'b1;
        wr_data = dim_lvl;
        state_d = S_IDLE;
      end
      S_TOP_W1: state_d = S_TOP_W2;
      S_TOP_W2: begin
        rd_en   = 1'b1;
        state_d = S_FADE;
      end
      S_FADE: begin
        wr_en   = 1'b1;
        md_req  = '{op_a: top_q, op_b: {1'b0, s_comp}, div_sel: DIV_100};
        state_d = S_BOT_W1;
      end
      S_BOT_W1: state_d = S_BOT_W2;
      S_BOT_W2: begin
        md_req  = '{op_a: top_q - md_quot, op_b: {2'b0, frac_q}, div_sel: DIV_60};
        state_d = S_ADJ_W1;
      end
      S_ADJ_W1: state_d = S_ADJ_W2;
      S_ADJ_W2: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_next[LED_AW-1:0];
            state_d = S_FADE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (sector_q)
      3'd0: begin
        red = top_q; green = bot_q + adj_q; blue = bot_q;
      end
      3'd1: begin
        red = top_q - adj_q; green = top_q; blue = bot_q;
      end
      3'd2: begin
        red = bot_q; green = top_q; blue = bot_q + adj_q;
      end
      3'd3: begin
        red = bot_q; green = top_q - adj_q; blue = top_q;
      end
      3'd4: begin
        red = bot_q + adj_q; green = bot_q; blue = top_q;
      end
      default: begin
        red = top_q; green = bot_q; blue = top_q - adj_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      hue_q       <= HUE_RST;
      sat_limit_q <= SAT_LIMIT_RST;
      brightness_q <= BRIGHTNESS_RST;
      strip_on_q  <= STRIP_ON_RST;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_HUE:        hue_q        <= cfg_data_i;
          REG_SAT_LIMIT:  sat_limit_q  <= cfg_data_i[PCT_W-1:0];
          REG_BRIGHTNESS: brightness_q <= cfg_data_i[PCT_W-1:0];
          REG_STRIP_ON:   strip_on_q   <= cfg_data_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cnt_q     <= req_type_i ? '0 : led_index_i;
      dim_amt_q <= DIM_AMT_W'(DIM_BASE) + DIM_AMT_W'(dim_extra_i);
      sector_q  <= sector;
      frac_q    <= frac;
    end else if (out_load) begin
      cnt_q <= cnt_next;
    end
    if (state_q == S_TOP_W2) begin
      top_q <= md_quot;
    end
    if (state_q == S_BOT_W2) begin
      bot_q <= md_quot;
    end
    if (state_q == S_ADJ_W2) begin
      adj_q <= md_quot;
    end
    if (out_load) begin
      out_idx_q   <= cnt_q;
      out_red_q   <= red;
      out_green_q <= green;
      out_blue_q  <= blue;
      out_last_q  <= (cnt_q == LAST_IDX);
    end
  end

  lsfh_ram #(
    .WIDTH(SAT_W),
    .DEPTH(NUM_LEDS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  lsfh_muldiv u_muldiv (
    .clk_i  (clk_i),
    .req_i  (md_req),
    .quot_o (md_quot)
  );

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_red_q;
  assign green_o       = out_green_q;
  assign blue_o        = out_blue_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// File: design/lsfh_checker.sv
// ----------------------------------------------------------------------------
// lsfh_checker: port-level checks for the sparkle-fade renderer
// Watches the request and pixel channels and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfh_checker
  import lsfh_pkg::*;
#(
  parameter int NUM_LEDS = NUM_LEDS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  req_type_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [IDX_W-1:0]      pixel_index_o,
  input logic [COLOR_W-1:0]    red_o,
  input logic [COLOR_W-1:0]    green_o,
  input logic [COLOR_W-1:0]    blue_o,
  input logic                  last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_index_o) &&
      $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(last_o))
    else $error("pixel changed while stalled");

  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> !in_ready_o)
    else $error("frame request did not occupy the block");

  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("request taken before frame end");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> pixel_index_o == IDX_W'(NUM_LEDS - 1))
    else $error("last flag on wrong pixel");

endmodule

bind led_sparkle_fade_hsv_renderer lsfh_checker #(.NUM_LEDS(NUM_LEDS)) u_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: sparkle-fade HSV renderer testbench
// Drives dim and frame requests through the valid/ready input, collects the
// rendered pixels and compares every field against an internal model of the
// per-LED levels and the six-sector HSV conversion. Runs a directed table,
// then random traffic over several register settings and idling patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import lsfh_pkg::*;

  localparam int NUM_LEDS      = NUM_LEDS_DEF;
  localparam int NUM_PHASES    = 7;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 1000000;

  localparam logic REQ_DIM   = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic               req;
    logic [IDX_W-1:0]   led;
    logic [EXTRA_W-1:0] extra;
    logic               typed;
    rgb_t               color;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  req_type_i;
  logic [IDX_W-1:0]      led_index_i;
  logic [EXTRA_W-1:0]    dim_extra_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [IDX_W-1:0]      pixel_index_o;
  logic [COLOR_W-1:0]    red_o;
  logic [COLOR_W-1:0]    green_o;
  logic [COLOR_W-1:0]    blue_o;
  logic                  last_o;

  led_sparkle_fade_hsv_renderer #(
    .NUM_LEDS(NUM_LEDS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .led_index_i  (led_index_i),
    .dim_extra_i  (dim_extra_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_index_o(pixel_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_o       (last_o)
  );

  logic signed [SAT_W-1:0] led_level [NUM_LEDS];
  logic [HUE_W-1:0]        hue_q;
  logic [PCT_W-1:0]        limit_q;
  logic [PCT_W-1:0]        bright_q;
  logic                    strip_on_q;

  pixel_t    pending_pixels [$];
  stim_row_t directed_rows [$];

  int error_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit rx_hold_req = 1'b0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic rgb_t hsv_color(input int hue, input int sat, input int val);
    int   top;
    int   bot;
    int   adj;
    int   frac;
    int   sector;
    rgb_t c;
    hue = hue % HUE_FULL;
    if (sat > PCT_MAX) sat = PCT_MAX;
    if (val > PCT_MAX) val = PCT_MAX;
    top    = (val * RGB_FULL) / PCT_MAX;
    bot    = (top * (PCT_MAX - sat)) / PCT_MAX;
    sector = hue / SECTOR_SPAN;
    frac   = hue % SECTOR_SPAN;
    adj    = ((top - bot) * frac) / SECTOR_SPAN;
    case (sector)
      0: begin
        c.red = COLOR_W'(top); c.green = COLOR_W'(bot + adj); c.blue = COLOR_W'(bot);
      end
      1: begin
        c.red = COLOR_W'(top - adj); c.green = COLOR_W'(top); c.blue = COLOR_W'(bot);
      end
      2: begin
        c.red = COLOR_W'(bot); c.green = COLOR_W'(top); c.blue = COLOR_W'(bot + adj);
      end
      3: begin
        c.red = COLOR_W'(bot); c.green = COLOR_W'(top - adj); c.blue = COLOR_W'(top);
      end
      4: begin
        c.red = COLOR_W'(bot + adj); c.green = COLOR_W'(bot); c.blue = COLOR_W'(top);
      end
      default: begin
        c.red = COLOR_W'(top); c.green = COLOR_W'(bot); c.blue = COLOR_W'(top - adj);
      end
    endcase
    return c;
  endfunction

  task automatic dim_led(input logic [IDX_W-1:0] led, input logic [EXTRA_W-1:0] extra);
    int lv;
    if (int'(led) < NUM_LEDS) begin
      lv = int'(led_level[led]) - (DIM_BASE + int'(extra));
      if (lv < -128) lv = -128;
      led_level[led] = SAT_W'(lv);
    end
  endtask

  task automatic render_frame(input logic typed, input rgb_t color);
    int     lv;
    int     val;
    rgb_t   c;
    pixel_t p;
    val = strip_on_q ? int'(bright_q) : 0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      lv = int'(led_level[i]) + FADE_STEP;
      if (lv < 0) lv = 0;
      if (lv > int'(limit_q)) lv = int'(limit_q);
      led_level[i] = SAT_W'(lv);
      c = typed ? color : hsv_color(int'(hue_q), lv, val);
      p.index = IDX_W'(i);
      p.red   = c.red;
      p.green = c.green;
      p.blue  = c.blue;
      p.last  = (i == NUM_LEDS - 1);
      pending_pixels.push_back(p);
    end
  endtask

  task automatic add_row(input logic req, input int led, input int extra, input logic typed,
                         input int r, input int g, input int b);
    stim_row_t row;
    row.req         = req;
    row.led         = IDX_W'(led);
    row.extra       = EXTRA_W'(extra);
    row.typed       = typed;
    row.color.red   = COLOR_W'(r);
    row.color.green = COLOR_W'(g);
    row.color.blue  = COLOR_W'(b);
    directed_rows.push_back(row);
  endtask

  task automatic send_request(input stim_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= row.req;
    led_index_i <= row.led;
    dim_extra_i <= row.extra;
    do @(posedge clk_i); while (!in_ready_o);
    if (row.req == REQ_FRAME) render_frame(row.typed, row.color);
    else dim_led(row.led, row.extra);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (index)
      REG_HUE:        hue_q      = data[HUE_W-1:0];
      REG_SAT_LIMIT:  limit_q    = data[PCT_W-1:0];
      REG_BRIGHTNESS: bright_q   = data[PCT_W-1:0];
      default:        strip_on_q = data[0];
    endcase
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // receive side: check accepted pixels, then pick ready for the next edge
  initial begin
    int     hold_left;
    pixel_t exp_px;
    hold_left   = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual index %0d rgb %0d %0d %0d",
                   $time, pixel_index_o, red_o, green_o, blue_o);
          error_count++;
        end else begin
          exp_px = pending_pixels.pop_front();
          check_field("index", exp_px.index, pixel_index_o);
          check_field("red", exp_px.red, red_o);
          check_field("green", exp_px.green, green_o);
          check_field("blue", exp_px.blue, blue_o);
          check_field("last", exp_px.last, last_o);
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t row;
    int        hue_v;
    int        limit_v;
    int        bright_v;
    int        on_v;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_DIM;
    led_index_i = '0;
    dim_extra_i = '0;
    hue_q       = HUE_RST;
    limit_q     = SAT_LIMIT_RST;
    bright_q    = BRIGHTNESS_RST;
    strip_on_q  = STRIP_ON_RST;
    for (int i = 0; i < NUM_LEDS; i++) led_level[i] = '0;

    // first two frames after reset: every level equal, colors read off directly
    add_row(REQ_FRAME, 0, 0, 1'b1, 255, 237, 237);
    add_row(REQ_FRAME, 63, 31, 1'b1, 255, 219, 219);
    add_row(REQ_DIM, 0, 0, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, NUM_LEDS - 1, 24, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 63, 31, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, NUM_LEDS, 5, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 1, 31, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 1, 31, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 1, 31, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 1, 31, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 2, 24, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 42, 21, 1'b0, 0, 0, 0);
    add_row(REQ_FRAME, 21, 10, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 30, 16, 1'b0, 0, 0, 0);
    add_row(REQ_DIM, 45, 8, 1'b0, 0, 0, 0);
    add_row(REQ_FRAME, 0, 0, 1'b0, 0, 0, 0);
    add_row(REQ_FRAME, 63, 31, 1'b0, 0, 0, 0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        tx_idle_pct = 34;
        rx_idle_pct = 49;
      end else if (p < 4) begin
        tx_idle_pct = 49;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: begin hue_v = 0;   limit_v = 100; bright_v = 100; on_v = 1; end
        1: begin hue_v = 359; limit_v = 127; bright_v = 127; on_v = 1; end
        2: begin hue_v = 360; limit_v = 0;   bright_v = 50;  on_v = 1; end
        3: begin hue_v = 511; limit_v = 60;  bright_v = 0;   on_v = 1; end
        4: begin hue_v = 200; limit_v = 100; bright_v = 100; on_v = 0; end
        5: begin hue_v = 90;  limit_v = 35;  bright_v = 73;  on_v = 1; end
        default: begin
          hue_v    = $urandom_range(511);
          limit_v  = $urandom_range(127);
          bright_v = $urandom_range(127);
          on_v     = $urandom_range(1);
        end
      endcase
      write_reg(REG_HUE, CFG_DATA_W'(hue_v));
      write_reg(REG_SAT_LIMIT, CFG_DATA_W'(limit_v));
      write_reg(REG_BRIGHTNESS, CFG_DATA_W'(bright_v));
      write_reg(REG_STRIP_ON, CFG_DATA_W'(on_v));
      cfg_we_i <= 1'b0;

      if (p == 0) begin
        foreach (directed_rows[k]) send_request(directed_rows[k]);
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the output side long enough to back up the input
        if (p == 1 && n == 10) rx_hold_req = 1'b1;
        if (p == 3 && n == 20) drain_results();
        row.typed = 1'b0;
        row.color = '0;
        row.req   = ($urandom_range(99) < 25) ? REQ_FRAME : REQ_DIM;
        if ($urandom_range(99) < 85) row.led = IDX_W'($urandom_range(NUM_LEDS - 1));
        else row.led = IDX_W'($urandom_range(63, NUM_LEDS));
        if ($urandom_range(99) < 85) row.extra = EXTRA_W'($urandom_range(24));
        else row.extra = EXTRA_W'($urandom_range(31, 25));
        send_request(row);
      end
      drain_results();
    end

    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/lsfh_pkg.sv
design/lsfh_ram.sv
design/lsfh_muldiv.sv
design/led_sparkle_fade_hsv_renderer.sv
design/lsfh_checker.sv
sim/tb_top.sv
